@@ rtl/whlm_pkg.sv @@
// shared types for the windowed high/low midpoint block
package whlm_pkg;

  // per-cell control from the sequencer
  typedef struct packed {
    logic shift;   // a new bar enters the row, every cell takes its neighbor's bar
    logic active;  // the cell lies inside the current window
  } cell_ctl_t;

  // bit width, rounded up to whole bytes, that a field group of the given bit count packs into
  function automatic int unsigned byte_pad(input int unsigned nbits);
    byte_pad = ((nbits + 7) / 8) * 8;
  endfunction

endpackage

@@ rtl/whlm_cell.sv @@
// one window cell: holds one bar and folds it into the passing max/min
module whlm_cell #(
  parameter int unsigned PRICE_BITS = 32
) (
  input  logic                  clk,
  input  whlm_pkg::cell_ctl_t   ctl,
  input  logic [PRICE_BITS-1:0] in_high,
  input  logic [PRICE_BITS-1:0] in_low,
  output logic [PRICE_BITS-1:0] hold_high,
  output logic [PRICE_BITS-1:0] hold_low,
  input  logic [PRICE_BITS-1:0] acc_in_high,
  input  logic [PRICE_BITS-1:0] acc_in_low,
  output logic [PRICE_BITS-1:0] acc_high,
  output logic [PRICE_BITS-1:0] acc_low
);

  logic [PRICE_BITS-1:0] acc_high_next;
  logic [PRICE_BITS-1:0] acc_low_next;

  // stored bar, shifted one place down the row per new bar
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      hold_high <= in_high;
      hold_low  <= in_low;
    end
  end

  // running extremes, only cells inside the window take part
  always_comb begin
    acc_high_next = acc_in_high;
    acc_low_next  = acc_in_low;
    if (ctl.active) begin
      if (hold_high > acc_in_high) begin
        acc_high_next = hold_high;
      end
      if (hold_low < acc_in_low) begin
        acc_low_next = hold_low;
      end
    end
  end

  // the accumulator moves one cell down in every cycle
  always_ff @(posedge clk) begin
    acc_high <= acc_high_next;
    acc_low  <= acc_low_next;
  end

endmodule

@@ rtl/window_high_low_midpoint.sv @@
// top level: windowed high/low midpoint over a row of bar cells
//
//  channel  dir  handshake            payload
//  s        in   s_tvalid / s_tready  s_tdata = bar_high, bar_low; s_tlast = series_end
//  m        out  m_tvalid / m_tready  m_tdata = midpoint_x2
//  cfg      in   cfg_valid/cfg_ready  cfg_data = window_period
//
// a bar that gives no result leaves the sequencer idle, ready for the next bar; a
// bar that gives a result starts a scan, in which the max/min accumulator walks
// down the MAX_PERIOD cells, then waits in the done state for m_tready on the previous result.
// reset clears the bar count and the sequencer; window cells are not cleared.
// a stalled result holds in the output register while the next bar is taken.
module window_high_low_midpoint #(
  parameter int unsigned MAX_PERIOD = 64,
  parameter int unsigned PRICE_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  // s_tdata fields from bit 0: bar_high, bar_low, zero pad
  input  logic [whlm_pkg::byte_pad(2 * PRICE_BITS)-1:0] s_tdata,
  input  logic                                          s_tvalid,
  output logic                                          s_tready,
  input  logic                                          s_tlast,
  // m_tdata fields from bit 0: midpoint_x2, zero pad
  output logic [whlm_pkg::byte_pad(PRICE_BITS + 1)-1:0] m_tdata,
  output logic                                          m_tvalid,
  input  logic                                          m_tready,
  // cfg_data fields from bit 0: window_period
  input  logic [6:0]                                    cfg_data,
  input  logic                                          cfg_valid,
  output logic                                          cfg_ready
);

  localparam int unsigned MW = whlm_pkg::byte_pad(PRICE_BITS + 1);
  localparam int unsigned PW = $clog2(MAX_PERIOD + 1);
  localparam int unsigned CW = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t                state;
  logic [CW-1:0]         cnt;
  logic [PW-1:0]         bars_seen;
  logic [6:0]            window_period;
  logic [PW-1:0]         p_eff;
  logic [PW-1:0]         bars_seen_next;
  logic                  accept;
  logic                  emit;
  logic [PRICE_BITS:0]   mid_sum;

  logic [PRICE_BITS-1:0] new_high;
  logic [PRICE_BITS-1:0] new_low;
  logic [PRICE_BITS-1:0] hold_high [MAX_PERIOD];
  logic [PRICE_BITS-1:0] hold_low  [MAX_PERIOD];
  logic [PRICE_BITS-1:0] acc_high  [MAX_PERIOD];
  logic [PRICE_BITS-1:0] acc_low   [MAX_PERIOD];

  assign new_high = s_tdata[PRICE_BITS-1:0];
  assign new_low  = s_tdata[2*PRICE_BITS-1:PRICE_BITS];

  // configuration register, written only while idle
  assign cfg_ready = (state == ST_IDLE);
  always_ff @(posedge clk) begin
    if (rst) begin
      window_period <= 7'd9;
    end else if (cfg_valid && cfg_ready) begin
      window_period <= cfg_data;
    end
  end

  // period clamped into 1 .. MAX_PERIOD
  always_comb begin
    if (window_period == 7'd0) begin
      p_eff = PW'(1);
    end else if (32'(window_period) > 32'(MAX_PERIOD)) begin
      p_eff = PW'(MAX_PERIOD);
    end else begin
      p_eff = PW'(window_period);
    end
  end

  // bar count after this beat, saturating at the row length
  assign accept         = s_tvalid && s_tready;
  assign bars_seen_next = (bars_seen == PW'(MAX_PERIOD)) ? bars_seen : bars_seen + PW'(1);
  assign emit           = (bars_seen_next >= p_eff);
  assign s_tready       = (state == ST_IDLE);

  // row of cells, cell 0 holds the newest bar
  for (genvar k = 0; k < MAX_PERIOD; k++) begin : g_cell
    whlm_pkg::cell_ctl_t ctl;
    assign ctl.shift  = accept;
    assign ctl.active = (32'(k) < 32'(p_eff));
    if (k == 0) begin : g_head
      whlm_cell #(.PRICE_BITS(PRICE_BITS)) u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .in_high     (new_high),
        .in_low      (new_low),
        .hold_high   (hold_high[k]),
        .hold_low    (hold_low[k]),
        .acc_in_high ({PRICE_BITS{1'b0}}),
        .acc_in_low  ({PRICE_BITS{1'b1}}),
        .acc_high    (acc_high[k]),
        .acc_low     (acc_low[k])
      );
    end else begin : g_body
      whlm_cell #(.PRICE_BITS(PRICE_BITS)) u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .in_high     (hold_high[k-1]),
        .in_low      (hold_low[k-1]),
        .hold_high   (hold_high[k]),
        .hold_low    (hold_low[k]),
        .acc_in_high (acc_high[k-1]),
        .acc_in_low  (acc_low[k-1]),
        .acc_high    (acc_high[k]),
        .acc_low     (acc_low[k])
      );
    end
  end

  // max high plus min low from the end of the row
  assign mid_sum = {1'b0, acc_high[MAX_PERIOD-1]} + {1'b0, acc_low[MAX_PERIOD-1]};

  // sequencer with bar count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      bars_seen <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (state == ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            bars_seen <= s_tlast ? '0 : bars_seen_next;
            cnt       <= '0;
            if (emit) begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(MAX_PERIOD - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result payload, loaded as the sequencer leaves the done state
  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= MW'(mid_sum);
    end
  end

`ifndef SYNTH
  a_emit_scans: assert property (@(posedge clk) disable iff (rst)
    (accept && emit) |=> (state == ST_SCAN))
    else $error("bar with a full window did not start the scan");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (32'(bars_seen) <= 32'(MAX_PERIOD)))
    else $error("bar count above the row length");

  a_no_shift_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !accept)
    else $error("cells shifted during a scan");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && (!m_tvalid || m_tready)) |=> (m_tvalid && state == ST_IDLE))
    else $error("finished scan did not reach the output register");
`endif

endmodule
